/* rtl/core/aelu_pkg.sv */
// Package for the auto exposure ladder unit: ladder thresholds and values,
// configuration register indexes, and the ladder lookup function.
// Used by aelu_accum, aelu_ladder and auto_exposure_ladder_unit; depends on nothing.
package aelu_pkg;

    localparam int CHAN_W = 8;
    localparam int EXP_W  = 7;
    localparam int TGT_W  = 9;
    localparam int BAND_W = 8;
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 8'd1;

    localparam logic [BAND_W-1:0] BAND_RESET = 8'd100;
    localparam logic [EXP_W-1:0]  EXP_RESET  = 7'd1;

    // band edges of the ladder
    localparam logic [EXP_W-1:0] EDGE_5  = 7'd5;
    localparam logic [EXP_W-1:0] EDGE_10 = 7'd10;
    localparam logic [EXP_W-1:0] EDGE_20 = 7'd20;
    localparam logic [EXP_W-1:0] EDGE_30 = 7'd30;
    localparam logic [EXP_W-1:0] EDGE_60 = 7'd60;

    // ladder step values
    localparam logic [EXP_W-1:0] EXP_1   = 7'd1;
    localparam logic [EXP_W-1:0] EXP_5   = 7'd5;
    localparam logic [EXP_W-1:0] EXP_10  = 7'd10;
    localparam logic [EXP_W-1:0] EXP_20  = 7'd20;
    localparam logic [EXP_W-1:0] EXP_25  = 7'd25;
    localparam logic [EXP_W-1:0] EXP_30  = 7'd30;
    localparam logic [EXP_W-1:0] EXP_50  = 7'd50;
    localparam logic [EXP_W-1:0] EXP_100 = 7'd100;

    typedef struct packed {
        logic [EXP_W-1:0] down;
        logic [EXP_W-1:0] up;
        logic             top;
    } ladder_t;

    function automatic ladder_t ladder_lookup(input logic [EXP_W-1:0] e);
        ladder_t r;
        r.top = 1'b0;
        r.up  = e;
        priority if (e < EDGE_5)
        begin
            r.down = EXP_1;
            r.up   = EXP_5;
        end
        else if (e < EDGE_10)
        begin
            r.down = EXP_1;
            r.up   = EXP_10;
        end
        else if (e < EDGE_20)
        begin
            r.down = EXP_5;
            r.up   = EXP_25;
        end
        else if (e < EDGE_30)
        begin
            r.down = EXP_10;
            r.up   = EXP_50;
        end
        else if (e < EDGE_60)
        begin
            r.down = EXP_20;
            r.up   = EXP_100;
        end
        else
        begin
            // top band: no step up
            r.down = EXP_30;
            r.top  = 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/core/aelu_accum.sv */
// Brightness accumulator: per-frame max of the three channel means, window
// frame counter and running sum; registers the sum of a closing window.
// Depends on aelu_pkg.
module aelu_accum
    import aelu_pkg::*;
#(
    parameter int WINDOW_FRAMES = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [CHAN_W-1:0]    chan0_mean,
    input  logic [CHAN_W-1:0]    chan1_mean,
    input  logic [CHAN_W-1:0]    chan2_mean,
    output logic [$clog2(255*WINDOW_FRAMES+1)-1:0] win_sum,
    output logic                 win_closed
);

    localparam int SUM_W = $clog2(255*WINDOW_FRAMES+1);
    localparam int CNT_W = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_FRAMES-1);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  sum_total;
    logic [SUM_W-1:0]  win_sum_reg;
    logic              win_closed_reg;
    logic [CHAN_W-1:0] max01, level;
    logic              last;

    always_comb
    begin
        max01     = (chan1_mean > chan0_mean) ? chan1_mean : chan0_mean;
        level     = (chan2_mean > max01) ? chan2_mean : max01;
        sum_total = sum_reg + SUM_W'(level);
        last      = (count_reg == CNT_LAST);
        count_next = last ? '0 : count_reg + CNT_W'(1);
        sum_next   = last ? '0 : sum_total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            sum_reg        <= '0;
            win_closed_reg <= 1'b0;
        end
        else if (load)
        begin
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            win_closed_reg <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            win_sum_reg <= sum_total;
        end
    end

    assign win_sum    = win_sum_reg;
    assign win_closed = win_closed_reg;

endmodule

/* rtl/core/aelu_ladder.sv */
// Window mean by reciprocal multiply, deadband compare and exposure ladder
// step; holds exposure and last mean, which double as the result register.
// Depends on aelu_pkg.
module aelu_ladder
    import aelu_pkg::*;
#(
    parameter int WINDOW_FRAMES = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [$clog2(255*WINDOW_FRAMES+1)-1:0] win_sum,
    input  logic                 win_closed,
    input  logic [TGT_W-1:0]     brightness_target,
    input  logic [BAND_W-1:0]    band_half_width,
    output logic [EXP_W-1:0]     exposure_setting,
    output logic                 exposure_written,
    output logic                 window_complete,
    output logic [CHAN_W-1:0]    mean_level
);

    localparam int SUM_W   = $clog2(255*WINDOW_FRAMES+1);
    localparam int SHIFT   = SUM_W + $clog2(WINDOW_FRAMES);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / W): exact floor division for every SUM_W-bit sum
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_FRAMES) - 64'd1) / 64'(WINDOW_FRAMES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int DIFF_W = 11;

    logic [EXP_W-1:0]  exposure_reg, exposure_next;
    logic [CHAN_W-1:0] last_mean_reg, last_mean_next;
    logic              written_reg, written_next;
    logic              complete_reg;

    logic [PROD_W-1:0]        prod;
    logic [CHAN_W-1:0]        mean;
    logic signed [DIFF_W-1:0] diff, band_s;
    logic                     bright, dark, step_up;
    ladder_t                  lad;

    always_comb
    begin
        prod    = PROD_W'(win_sum) * PROD_W'(RECIP);
        mean    = prod[SHIFT +: CHAN_W];
        diff    = $signed({3'b000, mean})
                - $signed({{(DIFF_W-TGT_W){brightness_target[TGT_W-1]}}, brightness_target});
        band_s  = $signed({3'b000, band_half_width});
        bright  = diff > band_s;
        dark    = diff < -band_s;
        lad     = ladder_lookup(exposure_reg);
        step_up = dark && !lad.top;
        written_next   = win_closed && (bright || step_up);
        last_mean_next = win_closed ? mean : last_mean_reg;
        exposure_next  = exposure_reg;
        if (win_closed && bright)
        begin
            exposure_next = lad.down;
        end
        else if (win_closed && step_up)
        begin
            exposure_next = lad.up;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exposure_reg  <= EXP_RESET;
            last_mean_reg <= '0;
            written_reg   <= 1'b0;
            complete_reg  <= 1'b0;
        end
        else if (load)
        begin
            exposure_reg  <= exposure_next;
            last_mean_reg <= last_mean_next;
            written_reg   <= written_next;
            complete_reg  <= win_closed;
        end
    end

    assign exposure_setting = exposure_reg;
    assign exposure_written = written_reg;
    assign window_complete  = complete_reg;
    assign mean_level       = last_mean_reg;

endmodule

/* rtl/core/auto_exposure_ladder_unit.sv */
// Auto exposure ladder unit, top level: stream ports, configuration
// registers, input register and stage handshake.
// Depends on aelu_pkg, aelu_accum, aelu_ladder.
//
// Channel   Dir  Payload
// s_axis    in   tdata: chan0_mean, chan1_mean, chan2_mean
// m_axis    out  tdata: exposure_setting, mean_level; tuser: exposure_written;
//                tlast: window_complete
// cfg       in   cfg_index (0 brightness_target, 1 band_half_width), cfg_data
//
// One word per cycle sustained while m_axis_tready holds; three register
// stages (input, window sum, result).
// Stages advance into any empty slot, so a waiting result does not stop
// accepted words behind it until all three stages are full.
// Reset clears the pipeline, the window, exposure to 1 and the mean to 0.
module auto_exposure_ladder_unit
    import aelu_pkg::*;
#(
    parameter int WINDOW_FRAMES = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // chan0_mean, chan1_mean, chan2_mean
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // exposure_setting, mean_level, zero pad
    output logic                 m_axis_tuser,   // exposure_written
    output logic                 m_axis_tlast,   // window_complete
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TGT_W-1:0]     cfg_data
);

    localparam int SUM_W = $clog2(255*WINDOW_FRAMES+1);

    logic [TGT_W-1:0]  target_reg;
    logic [BAND_W-1:0] band_reg;

    logic              v0_reg, v1_reg, v2_reg;
    logic              r1, r2;
    logic              load1, load2;
    logic [CHAN_W-1:0] c0_reg, c1_reg, c2_reg;

    logic [SUM_W-1:0]  win_sum;
    logic              win_closed;
    logic [EXP_W-1:0]  exposure_setting;
    logic              exposure_written;
    logic              window_complete;
    logic [CHAN_W-1:0] mean_level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            band_reg   <= BAND_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TARGET: target_reg <= cfg_data;
                CFG_BAND:   band_reg   <= cfg_data[BAND_W-1:0];
                default:    ;
            endcase
        end
    end

    // each stage takes a word when it is empty or its word moves on
    assign r2            = !v2_reg || m_axis_tready;
    assign r1            = !v1_reg || r2;
    assign s_axis_tready = !v0_reg || r1;
    assign load1         = v0_reg && r1;
    assign load2         = v1_reg && r2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                v0_reg <= s_axis_tvalid;
            end
            if (r1)
            begin
                v1_reg <= v0_reg;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            c0_reg <= s_axis_tdata[7:0];
            c1_reg <= s_axis_tdata[15:8];
            c2_reg <= s_axis_tdata[23:16];
        end
    end

    aelu_accum #(
        .WINDOW_FRAMES (WINDOW_FRAMES)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load1),
        .chan0_mean (c0_reg),
        .chan1_mean (c1_reg),
        .chan2_mean (c2_reg),
        .win_sum    (win_sum),
        .win_closed (win_closed)
    );

    aelu_ladder #(
        .WINDOW_FRAMES (WINDOW_FRAMES)
    ) u_ladder (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (load2),
        .win_sum           (win_sum),
        .win_closed        (win_closed),
        .brightness_target (target_reg),
        .band_half_width   (band_reg),
        .exposure_setting  (exposure_setting),
        .exposure_written  (exposure_written),
        .window_complete   (window_complete),
        .mean_level        (mean_level)
    );

    assign m_axis_tvalid = v2_reg;
    assign m_axis_tdata  = {1'b0, mean_level, exposure_setting};
    assign m_axis_tuser  = exposure_written;
    assign m_axis_tlast  = window_complete;

endmodule

/* verif/auto_exposure_ladder_unit_tb.sv */
// Testbench for auto_exposure_ladder_unit: queue-fed stream driver, result monitor
// and a predictor of the windowed brightness average and the exposure ladder.
// Depends on aelu_pkg and the auto_exposure_ladder_unit RTL.
module auto_exposure_ladder_unit_tb
    import aelu_pkg::*;
();

    localparam int WINDOW_FRAMES = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_PRINTS    = 30;

    // indexes with no register behind them; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = 8'hFF;

    typedef enum logic {ENT_FRAME, ENT_CFG} entry_kind_t;

    typedef struct {
        entry_kind_t           kind;
        logic [CHAN_W-1:0]     c0;
        logic [CHAN_W-1:0]     c1;
        logic [CHAN_W-1:0]     c2;
        logic [CFG_IDX_W-1:0]  idx;
        logic [TGT_W-1:0]      data;
        bit                    hold_mark;
    } stim_entry_t;

    typedef struct {
        logic [EXP_W-1:0]  exposure;
        logic              written;
        logic              closed;
        logic [CHAN_W-1:0] mean;
    } exposure_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    wire                  s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;
    wire                  m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    wire  [15:0]          m_axis_tdata;
    wire                  m_axis_tuser;
    wire                  m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    wire                  cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TGT_W-1:0]     cfg_data = '0;

    auto_exposure_ladder_unit #(.WINDOW_FRAMES(WINDOW_FRAMES)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    stim_entry_t      stim_q[$];
    exposure_result_t expected_results[$];

    int  cyc = 0;
    int  frames_planned = 0;
    int  frames_accepted = 0;
    int  results_seen = 0;
    int  reg_writes = 0;
    int  mismatches = 0;
    bit  hold = 1'b0;
    bit  hold_req = 1'b0;
    logic quiet;

    // shadow of the block: registers and window state
    logic signed [TGT_W-1:0] target_reg = '0;
    logic [BAND_W-1:0]       band_reg = BAND_RESET;
    int unsigned             win_count = 0;
    int unsigned             win_sum = 0;
    logic [EXP_W-1:0]        exp_now = EXP_RESET;
    logic [CHAN_W-1:0]       mean_held = '0;
    int windows_closed = 0;
    int steps_up = 0;
    int steps_down = 0;
    int in_band = 0;

    assign quiet = (cyc >= 1500) && (cyc < 2200);

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic log_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH @%0d: %s", cyc, msg);
        mismatches++;
    endtask

    // one ladder move on the shadow exposure; returns 1 when a sensor write goes out
    function automatic bit ladder_move(input bit bright, input bit dark);
        logic [EXP_W-1:0] dn;
        logic [EXP_W-1:0] upv;
        bit               top;
        top = 1'b0;
        if (exp_now < EDGE_5)
        begin
            dn = EXP_1;
            upv = EXP_5;
        end
        else if (exp_now < EDGE_10)
        begin
            dn = EXP_1;
            upv = EXP_10;
        end
        else if (exp_now < EDGE_20)
        begin
            dn = EXP_5;
            upv = EXP_25;
        end
        else if (exp_now < EDGE_30)
        begin
            dn = EXP_10;
            upv = EXP_50;
        end
        else if (exp_now < EDGE_60)
        begin
            dn = EXP_20;
            upv = EXP_100;
        end
        else
        begin
            dn = EXP_30;
            upv = exp_now;
            top = 1'b1;
        end
        if (bright)
        begin
            exp_now = dn;
            steps_down++;
            return 1'b1;
        end
        if (dark && !top)
        begin
            exp_now = upv;
            steps_up++;
            return 1'b1;
        end
        in_band++;
        return 1'b0;
    endfunction

    function automatic exposure_result_t predict_frame(input logic [CHAN_W-1:0] c0,
                                                       input logic [CHAN_W-1:0] c1,
                                                       input logic [CHAN_W-1:0] c2);
        exposure_result_t r;
        logic [CHAN_W-1:0] lvl;
        int diff;
        lvl = c0;
        if (c1 > lvl)
            lvl = c1;
        if (c2 > lvl)
            lvl = c2;
        win_sum += lvl;
        win_count++;
        r.written = 1'b0;
        r.closed = 1'b0;
        if (win_count >= WINDOW_FRAMES)
        begin
            r.closed = 1'b1;
            mean_held = CHAN_W'(win_sum / WINDOW_FRAMES);
            win_sum = 0;
            win_count = 0;
            windows_closed++;
            diff = int'(mean_held) - int'(target_reg);
            r.written = ladder_move(diff > int'(band_reg), diff < -int'(band_reg));
        end
        r.exposure = exp_now;
        r.mean = mean_held;
        return r;
    endfunction

    task automatic push_frame(input int c0, input int c1, input int c2);
        stim_entry_t e;
        e.kind = ENT_FRAME;
        e.c0 = c0[7:0];
        e.c1 = c1[7:0];
        e.c2 = c2[7:0];
        e.idx = '0;
        e.data = '0;
        e.hold_mark = 1'b0;
        stim_q.push_back(e);
        frames_planned++;
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [TGT_W-1:0] data);
        stim_entry_t e;
        e.kind = ENT_CFG;
        e.c0 = '0;
        e.c1 = '0;
        e.c2 = '0;
        e.idx = idx;
        e.data = data;
        e.hold_mark = 1'b0;
        stim_q.push_back(e);
    endtask

    // a window whose frame brightness stays within spread of lvl
    task automatic push_window(input int lvl, input int spread);
        int m;
        int pos;
        int a;
        int b;
        for (int i = 0; i < WINDOW_FRAMES; i++)
        begin
            m = lvl + $urandom_range(2 * spread) - spread;
            if (m < 0)
                m = 0;
            if (m > 255)
                m = 255;
            pos = $urandom_range(2);
            a = $urandom_range(m);
            b = $urandom_range(m);
            if (pos == 0)
                push_frame(m, a, b);
            else if (pos == 1)
                push_frame(a, m, b);
            else
                push_frame(a, b, m);
        end
    endtask

    task automatic push_noise(input int count);
        for (int i = 0; i < count; i++)
            push_frame($urandom_range(255), $urandom_range(255), $urandom_range(255));
    endtask

    // driver: frames on s_axis, register writes only with the pipeline drained
    always @(posedge clk)
    begin : drive_proc
        bit nxt_frame;
        bit nxt_cfg;
        bit gap;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (stim_q[0].hold_mark)
                    hold_req <= 1'b1;
                void'(stim_q.pop_front());
            end
            if (cfg_valid && cfg_ready)
                void'(stim_q.pop_front());
            gap = !quiet && !hold && ($urandom_range(99) < 12);
            nxt_frame = 1'b0;
            nxt_cfg = 1'b0;
            if (stim_q.size() > 0)
            begin
                if (stim_q[0].kind == ENT_FRAME)
                    nxt_frame = (s_axis_tvalid && !s_axis_tready) || !gap;
                else if (cfg_valid && !cfg_ready)
                    nxt_cfg = 1'b1;
                else if (!s_axis_tvalid && !(m_axis_tvalid && m_axis_tready)
                         && expected_results.size() == 0 && !gap)
                    nxt_cfg = 1'b1;
            end
            s_axis_tvalid <= nxt_frame;
            if (nxt_frame)
                s_axis_tdata <= {stim_q[0].c2, stim_q[0].c1, stim_q[0].c0};
            cfg_valid <= nxt_cfg;
            if (nxt_cfg)
            begin
                cfg_index <= stim_q[0].idx;
                cfg_data <= stim_q[0].data;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold && (quiet || $urandom_range(99) >= 12);
    end

    // long output stall once the marked word goes in, so the pipe fills and backs up
    initial
    begin
        @(posedge clk);
        while (!hold_req)
            @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    // monitor: checks each result word, tracks register writes and predicts accepted words
    always @(posedge clk)
    begin : monitor_proc
        exposure_result_t want;
        exposure_result_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.exposure = m_axis_tdata[6:0];
                got.mean = m_axis_tdata[14:7];
                got.written = m_axis_tuser;
                got.closed = m_axis_tlast;
                if (expected_results.size() == 0)
                    log_mismatch($sformatf("result %0d with nothing expected", results_seen));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.exposure !== want.exposure)
                        log_mismatch($sformatf("result %0d exposure_setting got %0d want %0d",
                                               results_seen, got.exposure, want.exposure));
                    if (got.mean !== want.mean)
                        log_mismatch($sformatf("result %0d mean_level got %0d want %0d",
                                               results_seen, got.mean, want.mean));
                    if (got.written !== want.written)
                        log_mismatch($sformatf("result %0d exposure_written got %b want %b",
                                               results_seen, got.written, want.written));
                    if (got.closed !== want.closed)
                        log_mismatch($sformatf("result %0d window_complete got %b want %b",
                                               results_seen, got.closed, want.closed));
                    if (m_axis_tdata[15] !== 1'b0)
                        log_mismatch($sformatf("result %0d pad bit not zero", results_seen));
                end
                results_seen <= results_seen + 1;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TARGET)
                    target_reg = cfg_data;
                else if (cfg_index == CFG_BAND)
                    band_reg = cfg_data[BAND_W-1:0];
                reg_writes <= reg_writes + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_frame(s_axis_tdata[7:0],
                                                         s_axis_tdata[15:8],
                                                         s_axis_tdata[23:16]));
                frames_accepted <= frames_accepted + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cyc);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : main_seq
        int m;
        int nwin;

        // defaults: a bright window at exposure 1 still issues the write
        push_frame(0, 0, 0);
        push_frame(255, 255, 255);
        push_frame(255, 0, 0);
        push_frame(0, 255, 0);
        push_frame(0, 0, 255);
        push_frame(254, 255, 1);
        push_frame(255, 254, 0);
        push_frame(128, 127, 255);
        push_frame(170, 85, 255);
        push_frame(255, 170, 85);
        push_frame(85, 255, 170);
        push_frame(1, 2, 3);
        push_frame(255, 255, 0);
        push_frame(0, 255, 255);
        push_frame(255, 0, 255);
        push_frame(127, 128, 129);
        push_frame(200, 200, 200);
        push_frame(255, 1, 254);
        push_frame(2, 255, 255);
        push_frame(250, 240, 230);
        push_window($urandom_range(255), 20);
        push_noise(WINDOW_FRAMES);

        // highest target, zero band: every window is dark, climb to the top band
        push_cfg(CFG_TARGET, 9'h0FF);
        push_cfg(CFG_BAND, 9'h000);
        for (int w = 0; w < 7; w++)
        begin
            push_window($urandom_range(100), 10);
            if (w == 2)
                stim_q[stim_q.size() - 10].hold_mark = 1'b1;
        end

        // lowest target, widest band: every window is bright, walk all the way down
        push_cfg(CFG_TARGET, 9'h100);
        push_cfg(CFG_BAND, 9'h0FF);
        push_window(255, 0);
        for (int w = 0; w < 5; w++)
            push_window($urandom_range(255), 15);

        // dropped writes, then mean exactly on target with a zero band: no step
        push_cfg(CFG_NO_REG, 9'h1FF);
        push_cfg(CFG_TOP_IDX, 9'h0AA);
        m = $urandom_range(255);
        push_cfg(CFG_TARGET, {1'b0, m[7:0]});
        push_cfg(CFG_BAND, 9'h000);
        push_window(m, 0);
        push_window(m, 0);

        // target zero, widest band: nothing can leave the band
        push_cfg(CFG_TARGET, 9'h000);
        push_cfg(CFG_BAND, 9'h0FF);
        push_window(255, 0);
        push_window(0, 0);

        // random settings, windows of steady brightness, some noise and split windows
        while (frames_planned < 1300)
        begin
            if ($urandom_range(3) != 0)
            begin
                if ($urandom_range(1) == 0)
                    push_cfg(CFG_TARGET, TGT_W'($urandom_range(511)));
                else
                    push_cfg(CFG_TARGET, TGT_W'($urandom_range(200)));
            end
            if ($urandom_range(3) != 0)
            begin
                if ($urandom_range(3) == 0)
                    push_cfg(CFG_BAND, TGT_W'($urandom_range(511)));
                else
                    push_cfg(CFG_BAND, TGT_W'($urandom_range(60)));
            end
            nwin = $urandom_range(1, 4);
            for (int w = 0; w < nwin; w++)
            begin
                if ($urandom_range(4) == 0)
                    push_noise(WINDOW_FRAMES);
                else
                    push_window($urandom_range(255), $urandom_range(30));
            end
            if ($urandom_range(3) == 0)
                push_noise($urandom_range(1, WINDOW_FRAMES - 1));
        end

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (12) @(posedge clk);

        if (expected_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("Run covered %0d frames in %0d closed windows with %0d register writes.",
                 frames_accepted, windows_closed, reg_writes);
        $display("Exposure moved up %0d times and down %0d times; %0d windows held still.",
                 steps_up, steps_down, in_band);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
